/* hdl/assert_macros.svh */
// Assertion macros used by the tape machine core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/tmwp_pkg.sv */
// Types, sizes and character codes of the tape machine.
`default_nettype none
package tmwp_pkg;
  localparam int CODE_AW = 12;
  localparam int CODE_DEPTH = 1 << CODE_AW;
  localparam int TAPE_AW = 15;
  localparam int TAPE_DEPTH = 1 << TAPE_AW;
  localparam int STACK_AW = 8;
  localparam int STACK_DEPTH = 1 << STACK_AW;
  localparam int PROC_AW = 8;
  localparam int PROC_COUNT = 1 << PROC_AW;
  localparam int CC_W = CODE_AW + 1;
  localparam int SD_W = STACK_AW + 1;

  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBRK = 8'h5B;
  localparam logic [7:0] CH_RBRK = 8'h5D;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_NL = 8'h0A;

  localparam logic [7:0] CON_CLEAR = 8'd0;
  localparam logic [7:0] CON_KEY = 8'd1;
  localparam logic [7:0] CON_STAT = 8'd2;
  localparam logic [7:0] CON_GOTO = 8'd3;

  typedef enum logic [3:0] {
    ST_RUN, ST_HALT, ST_PTR_OVER, ST_PTR_UNDER, ST_OPEN_BRK, ST_CLOSE_BRK,
    ST_OPEN_PAR, ST_CLOSE_PAR, ST_NO_PROC, ST_STACK_FULL, ST_BAD_RET, ST_OPEN_CMT
  } status_e;

  typedef enum logic [1:0] {EV_NONE, EV_BYTE, EV_CLS, EV_GOTO} event_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_FETCH, S_DECODE, S_SCAN_RD, S_SCAN_CK,
    S_CALL, S_RET, S_CUR1, S_CUR2, S_RESP
  } state_e;

  typedef enum logic [1:0] {SK_LINE, SK_BLOCK, SK_FWD, SK_BACK} scan_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] code_byte;
    logic       last_code;
    logic [7:0] in_byte;
    logic       in_eof;
    logic       key_ready;
  } item_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [1:0]         event_res;
    logic [7:0]         out_byte;
    logic [7:0]         cursor_x;
    logic [7:0]         cursor_y;
    logic               took_input;
    logic [CODE_AW-1:0] code_pos;
  } result_t;
endpackage
`default_nettype wire

/* hdl/tmwp_ram.sv */
// Generic RAM with one write port and one registered read port.
`default_nettype none
module tmwp_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [1<<AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/tmwp_core.sv */
// Sequencer and datapath that run one load or step request at a time through a sequence of states.
`default_nettype none
`include "assert_macros.svh"
module tmwp_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire tmwp_pkg::item_t  in_item_i,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  output tmwp_pkg::result_t     rsp_o
);
  import tmwp_pkg::*;

  state_e state_q, state_d;
  scan_e kind_q, kind_d;
  status_e status_q, status_d;
  item_t item_q, item_d;
  result_t res_q, res_d;
  logic [CC_W-1:0] cc_q, cc_d, len_q, len_d, idx_q, idx_d, level_q, level_d;
  logic [TAPE_AW-1:0] ptr_q, ptr_d, clr_q, clr_d;
  logic [SD_W-1:0] sd_q, sd_d;
  logic [PROC_COUNT-1:0] valid_q, valid_d;
  logic ls_q, ls_d, clr_pend_q, clr_pend_d, star_q, star_d;
  logic [7:0] op_q, op_d, cell_q, cell_d;

  logic prog_we, tape_we, proc_we, stack_we;
  logic [CODE_AW-1:0] prog_waddr, prog_raddr;
  logic [7:0] prog_wdata, prog_rdata, tape_wdata, tape_rdata;
  logic [TAPE_AW-1:0] tape_waddr, tape_raddr;
  logic [CODE_AW-1:0] proc_rdata, stack_rdata;
  logic [7:0] nxt, open_ch, close_ch, b;
  logic [CC_W-1:0] ld_idx;

  tmwp_ram #(.AW(CODE_AW), .DW(8)) u_prog (
    .clk_i, .we_i(prog_we), .waddr_i(prog_waddr), .wdata_i(prog_wdata),
    .raddr_i(prog_raddr), .rdata_o(prog_rdata));
  tmwp_ram #(.AW(TAPE_AW), .DW(8)) u_tape (
    .clk_i, .we_i(tape_we), .waddr_i(tape_waddr), .wdata_i(tape_wdata),
    .raddr_i(tape_raddr), .rdata_o(tape_rdata));
  tmwp_ram #(.AW(PROC_AW), .DW(CODE_AW)) u_proc (
    .clk_i, .we_i(proc_we), .waddr_i(cell_q), .wdata_i(cc_q[CODE_AW-1:0]),
    .raddr_i(cell_q), .rdata_o(proc_rdata));
  tmwp_ram #(.AW(STACK_AW), .DW(CODE_AW)) u_stack (
    .clk_i, .we_i(stack_we), .waddr_i(sd_q[STACK_AW-1:0]),
    .wdata_i(cc_q[CODE_AW-1:0]), .raddr_i(STACK_AW'(sd_q - 1'b1)),
    .rdata_o(stack_rdata));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      status_q <= ST_RUN;
      cc_q <= '0;
      len_q <= '0;
      ptr_q <= '0;
      clr_q <= '0;
      sd_q <= '0;
      valid_q <= '0;
      ls_q <= 1'b0;
      clr_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      status_q <= status_d;
      cc_q <= cc_d;
      len_q <= len_d;
      ptr_q <= ptr_d;
      clr_q <= clr_d;
      sd_q <= sd_d;
      valid_q <= valid_d;
      ls_q <= ls_d;
      clr_pend_q <= clr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    item_q <= item_d;
    res_q <= res_d;
    idx_q <= idx_d;
    level_q <= level_d;
    star_q <= star_d;
    op_q <= op_d;
    cell_q <= cell_d;
  end

  always_comb begin
    state_d = state_q;
    status_d = status_q;
    kind_d = kind_q;
    item_d = item_q;
    res_d = res_q;
    cc_d = cc_q;
    len_d = len_q;
    idx_d = idx_q;
    level_d = level_q;
    ptr_d = ptr_q;
    clr_d = clr_q;
    sd_d = sd_q;
    valid_d = valid_q;
    ls_d = ls_q;
    clr_pend_d = clr_pend_q;
    star_d = star_q;
    op_d = op_q;
    cell_d = cell_q;
    in_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    prog_we = 1'b0;
    prog_waddr = '0;
    prog_wdata = item_q.code_byte;
    prog_raddr = cc_q[CODE_AW-1:0];
    tape_we = 1'b0;
    tape_waddr = ptr_q;
    tape_wdata = '0;
    tape_raddr = ptr_q;
    proc_we = 1'b0;
    stack_we = 1'b0;
    ld_idx = ls_q ? len_q : '0;
    nxt = ((cc_q + 1'b1) < len_q) ? prog_rdata : 8'd0;
    open_ch = (op_q == CH_LPAR) ? CH_LPAR : CH_LBRK;
    close_ch = (op_q == CH_LPAR) ? CH_RPAR : CH_RBRK;
    b = prog_rdata;

    case (state_q)
      S_CLEAR: begin
        tape_we = 1'b1;
        tape_waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_item_i;
          res_d = '0;
          res_d.code_pos = cc_q[CODE_AW-1:0];
          if (!in_item_i.cmd) begin
            state_d = S_LOAD;
          end else if (status_q != ST_RUN) begin
            state_d = S_RESP;
          end else if (cc_q >= len_q) begin
            status_d = ST_HALT;
            state_d = S_RESP;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_LOAD: begin
        if (!ls_q) begin
          cc_d = '0;
          ptr_d = '0;
          sd_d = '0;
          valid_d = '0;
          status_d = ST_RUN;
          clr_pend_d = 1'b1;
        end
        res_d.code_pos = ld_idx[CODE_AW-1:0];
        len_d = ld_idx;
        if (ld_idx < CC_W'(CODE_DEPTH)) begin
          prog_we = 1'b1;
          prog_waddr = ld_idx[CODE_AW-1:0];
          len_d = ld_idx + 1'b1;
        end
        ls_d = !item_q.last_code;
        state_d = S_RESP;
      end
      S_FETCH: begin
        op_d = prog_rdata;
        cell_d = tape_rdata;
        prog_raddr = CODE_AW'(cc_q + 1'b1);
        if (prog_rdata == 8'd0) begin
          status_d = ST_HALT;
          state_d = S_RESP;
        end else begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        tape_raddr = ptr_q + 1'b1;
        state_d = S_RESP;
        cc_d = cc_q + 1'b1;
        if (op_q == CH_HASH || (op_q == CH_SLASH && nxt == CH_SLASH)) begin
          cc_d = cc_q;
          kind_d = SK_LINE;
          idx_d = cc_q + 1'b1;
          state_d = S_SCAN_RD;
        end else if (op_q == CH_SLASH && nxt == CH_STAR) begin
          cc_d = cc_q;
          kind_d = SK_BLOCK;
          idx_d = cc_q + CC_W'(2);
          star_d = 1'b0;
          state_d = S_SCAN_RD;
        end else begin
          case (op_q)
            CH_GT: begin
              if (ptr_q != TAPE_AW'(TAPE_DEPTH - 1)) begin
                ptr_d = ptr_q + 1'b1;
              end else begin
                status_d = ST_PTR_OVER;
                cc_d = cc_q;
              end
            end
            CH_LT: begin
              if (ptr_q != '0) begin
                ptr_d = ptr_q - 1'b1;
              end else begin
                status_d = ST_PTR_UNDER;
                cc_d = cc_q;
              end
            end
            CH_PLUS: begin
              tape_we = 1'b1;
              tape_wdata = cell_q + 1'b1;
            end
            CH_MINUS: begin
              tape_we = 1'b1;
              tape_wdata = cell_q - 1'b1;
            end
            CH_DOT: begin
              res_d.event_res = EV_BYTE;
              res_d.out_byte = cell_q;
            end
            CH_COMMA: begin
              res_d.took_input = 1'b1;
              tape_we = 1'b1;
              tape_wdata = item_q.in_eof ? 8'd0 : item_q.in_byte;
            end
            CH_LBRK: begin
              if (cell_q == 8'd0) begin
                cc_d = cc_q;
                kind_d = SK_FWD;
                idx_d = cc_q + 1'b1;
                level_d = CC_W'(1);
                state_d = S_SCAN_RD;
              end
            end
            CH_RBRK: begin
              if (cell_q != 8'd0) begin
                cc_d = cc_q;
                if (cc_q == '0) begin
                  status_d = ST_CLOSE_BRK;
                end else begin
                  kind_d = SK_BACK;
                  idx_d = cc_q - 1'b1;
                  level_d = CC_W'(1);
                  state_d = S_SCAN_RD;
                end
              end
            end
            CH_LPAR: begin
              cc_d = cc_q;
              proc_we = 1'b1;
              valid_d[cell_q] = 1'b1;
              kind_d = SK_FWD;
              idx_d = cc_q + 1'b1;
              level_d = CC_W'(1);
              state_d = S_SCAN_RD;
            end
            CH_RPAR, CH_SEMI: begin
              cc_d = cc_q;
              if (sd_q != '0) begin
                state_d = S_RET;
              end else begin
                status_d = (op_q == CH_RPAR) ? ST_CLOSE_PAR : ST_BAD_RET;
              end
            end
            CH_COLON: begin
              cc_d = cc_q;
              if (!valid_q[cell_q]) begin
                status_d = ST_NO_PROC;
              end else if (sd_q >= SD_W'(STACK_DEPTH)) begin
                status_d = ST_STACK_FULL;
              end else begin
                state_d = S_CALL;
              end
            end
            CH_BANG: begin
              case (cell_q)
                CON_CLEAR: res_d.event_res = EV_CLS;
                CON_KEY: begin
                  res_d.took_input = 1'b1;
                  tape_we = 1'b1;
                  tape_wdata = item_q.in_byte;
                end
                CON_STAT: begin
                  tape_we = 1'b1;
                  tape_wdata = {7'd0, item_q.key_ready};
                end
                CON_GOTO: begin
                  cc_d = cc_q;
                  state_d = S_CUR1;
                end
                default: ;
              endcase
            end
            CH_AT: begin
              cc_d = cc_q;
              status_d = ST_HALT;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        prog_raddr = idx_q[CODE_AW-1:0];
        state_d = S_SCAN_CK;
        if (kind_q != SK_BACK && idx_q >= len_q) begin
          state_d = S_RESP;
          case (kind_q)
            SK_LINE: cc_d = idx_q;
            SK_BLOCK: status_d = ST_OPEN_CMT;
            default: status_d = (op_q == CH_LPAR) ? ST_OPEN_PAR : ST_OPEN_BRK;
          endcase
        end
      end
      S_SCAN_CK: begin
        idx_d = idx_q + 1'b1;
        state_d = S_SCAN_RD;
        case (kind_q)
          SK_LINE: begin
            if (b == CH_NL || b == 8'd0) begin
              cc_d = idx_q;
              state_d = S_RESP;
            end
          end
          SK_BLOCK: begin
            star_d = (b == CH_STAR);
            if (star_q && b == CH_SLASH) begin
              cc_d = idx_q + 1'b1;
              state_d = S_RESP;
            end
          end
          SK_FWD: begin
            if (b == 8'd0) begin
              status_d = (op_q == CH_LPAR) ? ST_OPEN_PAR : ST_OPEN_BRK;
              state_d = S_RESP;
            end else if (b == open_ch) begin
              level_d = level_q + 1'b1;
            end else if (b == close_ch) begin
              level_d = level_q - 1'b1;
              if (level_q == CC_W'(1)) begin
                cc_d = idx_q + 1'b1;
                res_d.code_pos = idx_q[CODE_AW-1:0];
                state_d = S_RESP;
              end
            end
          end
          default: begin
            idx_d = idx_q - 1'b1;
            if (b == close_ch) begin
              level_d = level_q + 1'b1;
            end else if (b == open_ch) begin
              level_d = level_q - 1'b1;
            end
            if (b == open_ch && level_q == CC_W'(1)) begin
              cc_d = idx_q + 1'b1;
              res_d.code_pos = idx_q[CODE_AW-1:0];
              state_d = S_RESP;
            end else if (idx_q == '0) begin
              status_d = ST_CLOSE_BRK;
              state_d = S_RESP;
            end
          end
        endcase
      end
      S_CALL: begin
        stack_we = 1'b1;
        sd_d = sd_q + 1'b1;
        cc_d = {1'b0, proc_rdata} + 1'b1;
        res_d.code_pos = proc_rdata;
        state_d = S_RESP;
      end
      S_RET: begin
        sd_d = sd_q - 1'b1;
        cc_d = {1'b0, stack_rdata} + 1'b1;
        res_d.code_pos = stack_rdata;
        state_d = S_RESP;
      end
      S_CUR1: begin
        tape_raddr = ptr_q + TAPE_AW'(2);
        res_d.cursor_x = (ptr_q != TAPE_AW'(TAPE_DEPTH - 1)) ? tape_rdata : 8'd0;
        state_d = S_CUR2;
      end
      S_CUR2: begin
        res_d.cursor_y =
          (({1'b0, ptr_q} + (TAPE_AW+1)'(2)) < (TAPE_AW+1)'(TAPE_DEPTH)) ? tape_rdata : 8'd0;
        res_d.event_res = EV_GOTO;
        cc_d = cc_q + 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          clr_pend_d = 1'b0;
          state_d = clr_pend_q ? S_CLEAR : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_o = res_q;
    rsp_o.status = status_q;
  end

  `ASSERT_IMPL(a_sd_bound, 1'b1, sd_q <= SD_W'(STACK_DEPTH))
  `ASSERT_IMPL(a_cc_in_prog, state_q == S_IDLE, cc_q <= len_q)
  `ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, state_q != S_IDLE)
endmodule
`default_nettype wire

/* hdl/tape_machine_with_procedures.sv */
// Top level: stream ports, result register and the tape machine core.
`default_nettype none
// Tape machine with procedures. A request with tuser 0 stores one program
// byte, and tuser 1 runs one program step; each request gives one result.
// A load writes the byte in the load state, a plain step does program and tape
// memory reads, then the update, and a bracket, procedure or comment scan
// walks the program memory byte by byte through a read and a check state. After
// reset and after the first byte of each new program the tape memory is
// cleared one cell per cycle across all 32768 cells, during which no request is taken.
// A finished result waits in an output register while the next request enters.
module tape_machine_with_procedures (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // code_byte, in_byte, in_eof, key_ready
  input  wire logic        s_axis_tlast,  // last_code
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,  // status, out_byte, cursor_x, cursor_y,
                                          // took_input, code_pos
  output logic      [1:0]  m_axis_tuser   // event_res
);
  import tmwp_pkg::*;

  item_t item;
  result_t rsp, out_q, out_d;
  logic rsp_valid, rsp_ready, out_valid_q, out_valid_d;

  assign item.cmd = s_axis_tuser;
  assign item.code_byte = s_axis_tdata[7:0];
  assign item.last_code = s_axis_tlast;
  assign item.in_byte = s_axis_tdata[15:8];
  assign item.in_eof = s_axis_tdata[16];
  assign item.key_ready = s_axis_tdata[17];

  tmwp_core u_core (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(item),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp));

  assign rsp_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d = out_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
      out_d = rsp;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = out_q.event_res;
  assign m_axis_tdata = {7'd0, out_q.code_pos, out_q.took_input, out_q.cursor_y,
                         out_q.cursor_x, out_q.out_byte, out_q.status};
endmodule
`default_nettype wire
